// ===== hw/rtl/acu_pkg.sv =====
// Shared types and constants for the air-conditioner unit command responder.
// No dependencies; the top level in hw/rtl imports this package.
`default_nettype none

package acu_pkg;

  // Number of indoor units that the state memory holds.
  localparam int MAX_UNITS = 8;
  localparam int UNIT_IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int UNIT_CNT_W = $clog2(MAX_UNITS + 1);

  // One memory entry: power flag over setpoint in half degrees.
  localparam int SP_W = 8;
  localparam int ENTRY_W = SP_W + 1;

  // Response lengths and fixed body bytes.
  localparam logic [3:0] CHAR_LAST_BYTE = 4'd10;
  localparam logic [3:0] REC_LAST_BYTE = 4'd4;
  localparam logic [7:0] CUR_TEMP_BYTE = 8'd18;
  localparam logic [7:0] POWER_ON_BYTE = 8'h10;
  localparam logic [7:0] RESP_FLAG = 8'h80;
  localparam logic [SP_W-1:0] RESET_SETPOINT = 8'd36;

  // Configuration reset values.
  localparam logic [6:0] RESET_MAX_DEG = 7'd30;
  localparam logic [6:0] RESET_MIN_DEG = 7'd18;
  localparam logic [3:0] RESET_UNIT_COUNT = 4'd1;
  localparam logic [7:0] RESET_FIRST_ADDR = 8'd17;

  // Command codes.
  typedef enum logic [7:0] {
    CMD_STATUS   = 8'h01,
    CMD_CHAR     = 8'h0f,
    CMD_POWER    = 8'h43,
    CMD_SETPOINT = 8'h44
  } cmd_code_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_VERSION    = 3'd0,
    CFG_COMPANY    = 3'd1,
    CFG_MAX_DEG    = 3'd2,
    CFG_MIN_DEG    = 3'd3,
    CFG_UNIT_COUNT = 3'd4,
    CFG_FIRST_ADDR = 3'd5
  } cfg_reg_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHAR = 5'b00010,
    S_SCAN = 5'b00100,
    S_MOD  = 5'b01000,
    S_REC  = 5'b10000
  } seq_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/acu_ifs.sv =====
// Channel interfaces of the air-conditioner unit command responder:
// command input, response output and configuration write. No dependencies.
`default_nettype none

interface acu_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] command_type;
  logic [7:0] unit_address;
  logic [7:0] command_data;

  modport source (output valid, command_type, unit_address, command_data, input ready);
  modport sink (input valid, command_type, unit_address, command_data, output ready);
endinterface

interface acu_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] response_type;
  logic [7:0] body_byte;
  logic       last_byte;

  modport source (output valid, response_type, body_byte, last_byte, input ready);
  modport sink (input valid, response_type, body_byte, last_byte, output ready);
endinterface

interface acu_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] reg_index;
  logic [7:0] write_data;

  modport source (output valid, reg_index, write_data, input ready);
  modport sink (input valid, reg_index, write_data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/acu_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module acu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aircon_unit_command_responder.sv =====
// Top level of the air-conditioner unit command responder: command sequencer,
// configuration registers and output register. Depends on acu_pkg, acu_ifs, acu_ram.
//
// Usage: commands (type, unit address, first data byte) arrive on cmd; the
// response streams out on rsp one body byte per beat, last_byte marking the end
// of a response. Configuration registers are written through cfg, always ready.
// One command is handled at a time; cmd.ready is high only when the sequencer
// is idle. A characteristic command (0x0f) streams its body bytes out of the
// configuration registers. Status, power and setpoint commands walk the units
// in use: each unit gets a scan step, and each matching unit a modify step
// (the memory write-back for power and setpoint) and then its five-byte
// record; a final scan step closes the command.
// Device commands and unknown types get no response.
// The per-unit state sits in a small RAM with a registered read; the
// read-modify-write of one unit sets the pace. A stall on rsp holds the byte
// in the output register and pauses the sequencer.
// Reset returns the configuration to its defaults and marks every memory entry
// as never written, so it reads as power off and 18 degrees; no clearing
// pass is needed.
`default_nettype none

module aircon_unit_command_responder (
  input wire logic  clk,
  input wire logic  rst,
  acu_cmd_if.sink   cmd,
  acu_rsp_if.source rsp,
  acu_cfg_if.sink   cfg
);
  import acu_pkg::*;

  // Configuration registers.
  logic [7:0] version_code;
  logic [7:0] company_code;
  logic [6:0] max_setpoint_deg;
  logic [6:0] min_setpoint_deg;
  logic [3:0] unit_count;
  logic [7:0] first_unit_address;

  // Sequencer registers.
  seq_state_t                state;
  logic [7:0]                rtype;
  logic                      is_power;
  logic                      is_setpoint;
  logic                      power_new;
  logic [SP_W-1:0]           sp_new;
  logic [MAX_UNITS-1:0]      match_mask;
  logic [UNIT_CNT_W-1:0]     unit;
  logic [3:0]                byte_cnt;
  logic                      rec_power;
  logic [SP_W-1:0]           rec_sp;
  logic                      rec_last;
  logic [MAX_UNITS-1:0]      entry_valid;

  // Combinational helpers.
  logic [UNIT_CNT_W-1:0]     n_units;
  logic [MAX_UNITS-1:0]      mask_now;
  logic [UNIT_IDX_W-1:0]     unit_idx;
  logic [ENTRY_W-1:0]        ram_rdata;
  logic [ENTRY_W-1:0]        ram_wdata;
  logic                      ram_we;
  logic                      cur_power;
  logic [SP_W-1:0]           cur_sp;
  logic                      upd_power;
  logic [SP_W-1:0]           upd_sp;
  logic                      any_above;
  logic [SP_W-1:0]           sp_req;
  logic [SP_W-1:0]           sp_hi;
  logic [SP_W-1:0]           sp_lo;
  logic [SP_W-1:0]           sp_clamped;
  logic                      cmd_beat;
  logic                      out_free;
  logic                      out_load;
  logic [7:0]                out_byte;
  logic                      out_last;
  logic [7:0]                char_byte;
  logic [7:0]                rec_byte;

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == S_IDLE);
  assign cmd_beat  = cmd.valid && cmd.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign unit_idx  = unit[UNIT_IDX_W-1:0];

  // Units in use, saturated to the memory depth.
  always_comb begin
    if (unit_count > 4'(MAX_UNITS)) begin
      n_units = UNIT_CNT_W'(MAX_UNITS);
    end else begin
      n_units = UNIT_CNT_W'(unit_count);
    end
  end

  // Address match for every unit in use; low nibble 0xF addresses all.
  always_comb begin
    for (int j = 0; j < MAX_UNITS; j++) begin
      mask_now[j] = (UNIT_CNT_W'(j) < n_units) &&
                    ((cmd.unit_address[3:0] == 4'hf) ||
                     (cmd.unit_address == 8'(first_unit_address + 8'(j))));
    end
  end

  // Requested setpoint in half degrees, clamped high first, then low.
  always_comb begin
    sp_req = {cmd.command_data[6:0], cmd.command_data[7]};
    sp_hi  = {max_setpoint_deg, 1'b0};
    sp_lo  = {min_setpoint_deg, 1'b0};
    if (sp_req > sp_hi) begin
      sp_clamped = sp_hi;
    end else if (sp_req < sp_lo) begin
      sp_clamped = sp_lo;
    end else begin
      sp_clamped = sp_req;
    end
  end

  // Unit state memory: power flag over setpoint.
  acu_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_UNITS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (unit_idx),
    .wdata (ram_wdata),
    .raddr (unit_idx),
    .rdata (ram_rdata)
  );

  // Entries never written read as their reset value.
  always_comb begin
    if (entry_valid[unit_idx]) begin
      cur_power = ram_rdata[ENTRY_W-1];
      cur_sp    = ram_rdata[SP_W-1:0];
    end else begin
      cur_power = 1'b0;
      cur_sp    = RESET_SETPOINT;
    end
    upd_power = is_power ? power_new : cur_power;
    upd_sp    = is_setpoint ? sp_new : cur_sp;
    ram_wdata = {upd_power, upd_sp};
    ram_we    = (state == S_MOD) && (is_power || is_setpoint);
  end

  // Whether a later unit still matches; decides the final beat.
  always_comb begin
    any_above = 1'b0;
    for (int j = 0; j < MAX_UNITS; j++) begin
      if ((UNIT_IDX_W'(j) > unit_idx) && match_mask[j]) begin
        any_above = 1'b1;
      end
    end
  end

  // Characteristic body bytes.
  always_comb begin
    unique case (byte_cnt)
      4'd0:    char_byte = version_code;
      4'd1:    char_byte = company_code;
      4'd2:    char_byte = {4'd0, unit_count};
      4'd4:    char_byte = {1'b0, max_setpoint_deg};
      4'd5:    char_byte = {1'b0, min_setpoint_deg};
      default: char_byte = 8'd0;
    endcase
  end

  // Status record bytes.
  always_comb begin
    unique case (byte_cnt)
      4'd1:    rec_byte = rec_power ? POWER_ON_BYTE : 8'd0;
      4'd3:    rec_byte = {rec_sp[0], rec_sp[SP_W-1:1]};
      4'd4:    rec_byte = CUR_TEMP_BYTE;
      default: rec_byte = 8'd0;
    endcase
  end

  // Output beat selection.
  always_comb begin
    out_load = 1'b0;
    out_byte = rec_byte;
    out_last = 1'b0;
    if ((state == S_CHAR) && out_free) begin
      out_load = 1'b1;
      out_byte = char_byte;
      out_last = (byte_cnt == CHAR_LAST_BYTE);
    end else if ((state == S_REC) && out_free) begin
      out_load = 1'b1;
      out_byte = rec_byte;
      out_last = (byte_cnt == REC_LAST_BYTE) && rec_last;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      version_code       <= 8'd0;
      company_code       <= 8'd0;
      max_setpoint_deg   <= RESET_MAX_DEG;
      min_setpoint_deg   <= RESET_MIN_DEG;
      unit_count         <= RESET_UNIT_COUNT;
      first_unit_address <= RESET_FIRST_ADDR;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.reg_index)
        CFG_VERSION:    version_code       <= cfg.write_data;
        CFG_COMPANY:    company_code       <= cfg.write_data;
        CFG_MAX_DEG:    max_setpoint_deg   <= cfg.write_data[6:0];
        CFG_MIN_DEG:    min_setpoint_deg   <= cfg.write_data[6:0];
        CFG_UNIT_COUNT: unit_count         <= cfg.write_data[3:0];
        CFG_FIRST_ADDR: first_unit_address <= cfg.write_data;
        default: ;
      endcase
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_beat && !cmd.command_type[7]) begin
            if (cmd.command_type == CMD_CHAR) begin
              state <= S_CHAR;
            end else if ((cmd.command_type == CMD_STATUS) ||
                         (cmd.command_type == CMD_POWER) ||
                         (cmd.command_type == CMD_SETPOINT)) begin
              state <= S_SCAN;
            end
          end
        end
        S_CHAR: begin
          if (out_load && out_last) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (unit == n_units) begin
            state <= S_IDLE;
          end else if (match_mask[unit_idx]) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          state <= S_REC;
          if (ram_we) begin
            entry_valid[unit_idx] <= 1'b1;
          end
        end
        S_REC: begin
          if (out_load && (byte_cnt == REC_LAST_BYTE)) begin
            state <= S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (cmd_beat) begin
      rtype       <= cmd.command_type | RESP_FLAG;
      is_power    <= (cmd.command_type == CMD_POWER);
      is_setpoint <= (cmd.command_type == CMD_SETPOINT);
      power_new   <= (cmd.command_data != 8'd0);
      sp_new      <= sp_clamped;
      match_mask  <= mask_now;
      unit        <= '0;
      byte_cnt    <= 4'd0;
    end else begin
      if ((state == S_SCAN) && (unit != n_units) && !match_mask[unit_idx]) begin
        unit <= unit + 1'b1;
      end
      if (state == S_MOD) begin
        rec_power <= upd_power;
        rec_sp    <= upd_sp;
        rec_last  <= !any_above;
        byte_cnt  <= 4'd0;
      end
      if (out_load) begin
        byte_cnt <= byte_cnt + 4'd1;
        if ((state == S_REC) && (byte_cnt == REC_LAST_BYTE)) begin
          unit <= unit + 1'b1;
        end
      end
    end
  end

  // Output register: holds a beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.response_type <= rtype;
      rsp.body_byte     <= out_byte;
      rsp.last_byte     <= out_last;
    end
  end

endmodule

`default_nettype wire
